### rtl/bale_pkg.sv
// Shared types and codes for the bounded array list engine.
// Used by bale_cell, bale_ctrl and bounded_array_list_engine; no dependencies.
`timescale 1ns / 1ps

package bale_pkg;

  // Number of cells in the row. The port widths below are sized for it.
  localparam int unsigned DEPTH = 16;

  // Request kinds carried on in_kind.
  localparam logic [2:0] KIND_APPEND    = 3'd0;
  localparam logic [2:0] KIND_INSERT    = 3'd1;
  localparam logic [2:0] KIND_READ      = 3'd2;
  localparam logic [2:0] KIND_OVERWRITE = 3'd3;
  localparam logic [2:0] KIND_DELETE    = 3'd4;

  // Status codes carried on out_status.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Configuration register byte addresses.
  localparam logic [2:0] REG_CAPACITY = 3'd0;

  // Capacity register reset value and width.
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Fixed widths of the result fields.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned USED_W = 5;

  // Word value returned by a failed read.
  localparam logic [WORD_W-1:0] READ_FAIL = '1;

  // What one storage cell does at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_BELOW,
    CELL_FROM_ABOVE
  } cell_op_t;

  // One result item.
  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [1:0]               status;
    logic [USED_W-1:0]        entries_used;
    logic                     is_full;
    logic                     is_empty;
  } result_t;

endpackage

### rtl/bale_cell.sv
// One storage cell of the list: a single word that holds, loads the request
// value, or takes the word of its lower or upper neighbor. Uses bale_pkg.
`timescale 1ns / 1ps

module bale_cell
  import bale_pkg::*;
(
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [WORD_W-1:0] load_data,
  input  logic [WORD_W-1:0] below_data,
  input  logic [WORD_W-1:0] above_data,
  output logic [WORD_W-1:0] word
);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  // Select the next word from the shift controls.
  always_comb begin
    unique case (op)
      CELL_LOAD:       word_nxt = load_data;
      CELL_FROM_BELOW: word_nxt = below_data;
      CELL_FROM_ABOVE: word_nxt = above_data;
      default:         word_nxt = word_r;
    endcase
  end

  // Payload storage needs no reset; the entry count guards every read.
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

### rtl/bale_ctrl.sv
// Request decoder for the list: checks index and capacity, drives the per-cell
// shift controls, the next entry count and the result. Uses bale_pkg.
`timescale 1ns / 1ps

module bale_ctrl
  import bale_pkg::*;
(
  input  logic [2:0]                     kind,
  input  logic [4:0]                     position,
  input  logic [CAP_W-1:0]               capacity,
  input  logic [$clog2(DEPTH+1)-1:0]     count,
  input  logic [DEPTH-1:0][WORD_W-1:0]   words,
  output cell_op_t                       ops [DEPTH],
  output logic [$clog2(DEPTH+1)-1:0]     count_nxt,
  output result_t                        result
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W + 1 : 6;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] cap_x;
  logic [CMP_W-1:0] new_cnt;
  logic             full;
  logic             do_append;
  logic             do_insert;
  logic             do_write;
  logic             do_delete;
  logic [1:0]       status;
  logic [WORD_W-1:0] rd_word;

  // Common operands, all widened to one compare width.
  always_comb begin
    pos_x = CMP_W'(position);
    cnt_x = CMP_W'(count);
    cap_x = CMP_W'(capacity);
    if (cap_x == '0) begin
      cap_x = CMP_W'(1);
    end else if (cap_x > CMP_W'(DEPTH)) begin
      cap_x = CMP_W'(DEPTH);
    end
    full = (cnt_x >= cap_x);
  end

  // Decide what the request does and which status it reports.
  always_comb begin
    do_append = 1'b0;
    do_insert = 1'b0;
    do_write  = 1'b0;
    do_delete = 1'b0;
    status    = ST_OK;
    rd_word   = '0;
    new_cnt   = cnt_x;
    unique case (kind)
      KIND_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_append = 1'b1;
          new_cnt   = cnt_x + CMP_W'(1);
        end
      end
      KIND_INSERT: begin
        if (pos_x > cnt_x) begin
          status = ST_BAD_INDEX;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          do_insert = 1'b1;
          new_cnt   = cnt_x + CMP_W'(1);
        end
      end
      KIND_READ: begin
        if (pos_x >= cnt_x) begin
          status  = ST_BAD_INDEX;
          rd_word = READ_FAIL;
        end else begin
          rd_word = words[pos_x[IDX_W-1:0]];
        end
      end
      KIND_OVERWRITE: begin
        if (pos_x >= cnt_x) begin
          status = ST_BAD_INDEX;
        end else begin
          do_write = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (pos_x >= cnt_x) begin
          status = ST_BAD_INDEX;
        end else begin
          do_delete = 1'b1;
          new_cnt   = cnt_x - CMP_W'(1);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Per-cell controls: every cell compares its own index independently.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ops[i] = CELL_HOLD;
      if (do_append && (CMP_W'(i) == cnt_x)) begin
        ops[i] = CELL_LOAD;
      end else if ((do_insert || do_write) && (CMP_W'(i) == pos_x)) begin
        ops[i] = CELL_LOAD;
      end else if (do_insert && (CMP_W'(i) > pos_x) && (CMP_W'(i) <= cnt_x)) begin
        ops[i] = CELL_FROM_BELOW;
      end else if (do_delete && (CMP_W'(i) >= pos_x) && (CMP_W'(i + 1) < cnt_x)) begin
        ops[i] = CELL_FROM_ABOVE;
      end
    end
  end

  // Result fields follow the count after the request.
  always_comb begin
    count_nxt           = new_cnt[CNT_W-1:0];
    result.read_value   = rd_word;
    result.status       = status;
    result.entries_used = new_cnt[USED_W-1:0];
    result.is_full      = (new_cnt >= cap_x);
    result.is_empty     = (new_cnt == '0);
  end

endmodule

### rtl/bounded_array_list_engine.sv
// Bounded array list engine: a packed list of words held in a row of cells.
// Each result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while in_stall is low; all cells shift together in that cycle.
// Reset: the entry count clears and the capacity register returns to 16;
// cell contents are left as they are and become valid only once written.
// Depends on bale_pkg, bale_ctrl and bale_cell.
`timescale 1ns / 1ps

module bounded_array_list_engine
  import bale_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // Request channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_kind,
  input  logic [4:0]               in_position,
  input  logic signed [WORD_W-1:0] in_value,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_read_value,
  output logic [1:0]               out_status,
  output logic [USED_W-1:0]        out_entries_used,
  output logic                     out_is_full,
  output logic                     out_is_empty,
  // Configuration port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CAP_W-1:0]             cap_r;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic                         out_valid_r;
  result_t                      result_r;
  result_t                      result_nxt;
  logic                         in_xfer;
  logic [DEPTH-1:0][WORD_W-1:0] words;
  cell_op_t                     ops [DEPTH];
  cell_op_t                     cell_ops [DEPTH];

  // Configuration register access.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_CAPACITY) ? 32'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // A request moves in whenever the result register is free or draining.
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  bale_ctrl u_ctrl (
    .kind      (in_kind),
    .position  (in_position),
    .capacity  (cap_r),
    .count     (count_r),
    .words     (words),
    .ops       (ops),
    .count_nxt (count_nxt),
    .result    (result_nxt)
  );

  // Cells only change on an accepted request.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ops[i] = in_xfer ? ops[i] : CELL_HOLD;
    end
  end

  // Row of cells; each edge cell sees its own word past the end of the row.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] below_w;
    logic [WORD_W-1:0] above_w;
    if (g == 0) begin : g_lo
      assign below_w = words[g];
    end else begin : g_lo
      assign below_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign above_w = words[g];
    end else begin : g_hi
      assign above_w = words[g+1];
    end
    bale_cell u_cell (
      .clk        (clk),
      .op         (cell_ops[g]),
      .load_data  (in_value),
      .below_data (below_w),
      .above_data (above_w),
      .word       (words[g])
    );
  end

  // Entry count and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = result_r.read_value;
  assign out_status       = result_r.status;
  assign out_entries_used = result_r.entries_used;
  assign out_is_full      = result_r.is_full;
  assign out_is_empty     = result_r.is_empty;

endmodule
